@@ rtl/core/mai_pkg.sv @@
package mai_pkg;

   // field widths
   localparam int THR_W      = 12;
   localparam int PWM_W      = 10;
   localparam int HOLD_W     = 10;
   localparam int STEP_W     = 2;
   localparam int EV_W       = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   // throttle span mapped onto 0..pwm_max
   localparam logic [THR_W-1:0] THR_IN_MIN = THR_W'(1000);
   localparam logic [THR_W-1:0] THR_IN_MAX = THR_W'(2000);

   // scaled product (throttle offset times pwm_max) and divide-by-1000 reciprocal
   localparam int PROD_W      = 2 * PWM_W;
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 21;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);

   // hold limits in arming ticks
   localparam logic [HOLD_W-1:0] LOW_HOLD_TICKS  = HOLD_W'(20);
   localparam logic [HOLD_W-1:0] HIGH_HOLD_TICKS = HOLD_W'(100);
   localparam logic [HOLD_W-1:0] IDLE_LOCK_TICKS = HOLD_W'(600);

   typedef enum logic [STEP_W-1:0] {
      STEP_WAIT_LOW       = 2'd0,
      STEP_WAIT_HIGH      = 2'd1,
      STEP_WAIT_LOW_AGAIN = 2'd2,
      STEP_ARMED          = 2'd3
   } step_type;

   typedef enum logic [EV_W-1:0] {
      EV_NONE   = 3'd0,
      EV_LINK   = 3'd1,
      EV_MANUAL = 3'd2,
      EV_IDLE   = 3'd3,
      EV_STEP   = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARM_LOW_START     = 4'd0,
      CSR_ARM_LOW_DONE      = 4'd1,
      CSR_ARM_HIGH          = 4'd2,
      CSR_KILL_THROTTLE_LOW = 4'd3,
      CSR_KILL_YAW_LOW      = 4'd4,
      CSR_KILL_YAW_HIGH     = 4'd5,
      CSR_ACTIVE_THROTTLE   = 4'd6,
      CSR_PWM_MAX           = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0] arm_low_start;
      logic [THR_W-1:0] arm_low_done;
      logic [THR_W-1:0] arm_high;
      logic [THR_W-1:0] kill_throttle_low;
      logic [THR_W-1:0] kill_yaw_low;
      logic [THR_W-1:0] kill_yaw_high;
      logic [THR_W-1:0] active_throttle;
      logic [PWM_W-1:0] pwm_max;
   } cfg_type;

   // word held in the input register
   typedef struct packed {
      logic              mode;
      logic              link_up;
      logic [THR_W-1:0]  throttle;
      logic [THR_W-1:0]  yaw;
      logic              thr_le_min;
      logic              thr_ge_max;
      logic [PROD_W-1:0] scaled;
   } in_word_type;

   // arm controller outcome for the word in the input register
   typedef struct packed {
      logic      armed;
      step_type  step;
      event_type ev_code;
   } arm_result_type;

endpackage

@@ rtl/core/mai_if.sv @@
interface mai_req_if;
   import mai_pkg::*;

   logic             valid;
   logic             ready;
   logic             mode;
   logic             link_up;
   logic [THR_W-1:0] throttle;
   logic [THR_W-1:0] yaw;

   modport source (output valid, output mode, output link_up, output throttle,
                   output yaw, input ready);
   modport sink   (input valid, input mode, input link_up, input throttle,
                   input yaw, output ready);
endinterface

interface mai_rsp_if;
   import mai_pkg::*;

   logic              valid;
   logic              ready;
   logic              armed;
   logic [STEP_W-1:0] arm_step;
   logic [PWM_W-1:0]  motor_pwm;
   logic [EV_W-1:0]   event_res;

   modport source (output valid, output armed, output arm_step, output motor_pwm,
                   output event_res, input ready);
   modport sink   (input valid, input armed, input arm_step, input motor_pwm,
                   input event_res, output ready);
endinterface

@@ rtl/core/mai_csr.sv @@
module mai_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mai_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mai_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mai_pkg::cfg_type                  cfg
);
   import mai_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write; unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ARM_LOW_START:     cfg_in.arm_low_start     = csr_wdata[THR_W-1:0];
            CSR_ARM_LOW_DONE:      cfg_in.arm_low_done      = csr_wdata[THR_W-1:0];
            CSR_ARM_HIGH:          cfg_in.arm_high          = csr_wdata[THR_W-1:0];
            CSR_KILL_THROTTLE_LOW: cfg_in.kill_throttle_low = csr_wdata[THR_W-1:0];
            CSR_KILL_YAW_LOW:      cfg_in.kill_yaw_low      = csr_wdata[THR_W-1:0];
            CSR_KILL_YAW_HIGH:     cfg_in.kill_yaw_high     = csr_wdata[THR_W-1:0];
            CSR_ACTIVE_THROTTLE:   cfg_in.active_throttle   = csr_wdata[THR_W-1:0];
            CSR_PWM_MAX:           cfg_in.pwm_max           = csr_wdata[PWM_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // hold the register file, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arm_low_start     <= THR_W'(1040);
         cfg_ff.arm_low_done      <= THR_W'(1060);
         cfg_ff.arm_high          <= THR_W'(1940);
         cfg_ff.kill_throttle_low <= THR_W'(1100);
         cfg_ff.kill_yaw_low      <= THR_W'(1100);
         cfg_ff.kill_yaw_high     <= THR_W'(1900);
         cfg_ff.active_throttle   <= THR_W'(1300);
         cfg_ff.pwm_max           <= PWM_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/mai_in_stage.sv @@
module mai_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   mai_req_if.sink                      req,
   input  logic [mai_pkg::PWM_W-1:0]    pwm_max,
   input  logic                         advance,
   output logic                         in_valid,
   output mai_pkg::in_word_type         in_word
);
   import mai_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   in_word_type      word_ff;
   in_word_type      word_in;
   logic [THR_W-1:0] thr_off;
   logic             load;

   // take a word when the register is empty or drains this cycle
   assign req.ready = !valid_ff || advance;
   assign load      = req.valid && req.ready;

   // scale the throttle offset by pwm_max ahead of the register
   always_comb begin
      thr_off          = req.throttle - THR_IN_MIN;
      word_in.mode     = req.mode;
      word_in.link_up  = req.link_up;
      word_in.throttle = req.throttle;
      word_in.yaw      = req.yaw;
      word_in.thr_le_min = (req.throttle <= THR_IN_MIN);
      word_in.thr_ge_max = (req.throttle >= THR_IN_MAX);
      word_in.scaled   = PROD_W'(thr_off[PWM_W-1:0]) * PROD_W'(pwm_max);
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

@@ rtl/core/mai_arm_ctrl.sv @@
module mai_arm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mai_pkg::in_word_type        in_word,
   input  mai_pkg::cfg_type            cfg,
   output logic                        armed_now,
   output mai_pkg::arm_result_type     res_next
);
   import mai_pkg::*;

   step_type          step_ff;
   step_type          step_in;
   logic [HOLD_W-1:0] hold_ff;
   logic [HOLD_W-1:0] hold_in;
   logic              armed_ff;
   logic              armed_in;
   event_type         ev_code;
   logic [HOLD_W-1:0] hold_inc;
   logic              kill;
   logic              yaw_hard;

   assign hold_inc = hold_ff + HOLD_W'(1);
   assign yaw_hard = (in_word.yaw < cfg.kill_yaw_low) || (in_word.yaw > cfg.kill_yaw_high);
   assign kill     = !in_word.link_up ||
                     ((in_word.throttle < cfg.kill_throttle_low) && yaw_hard);

   // next arm state and event for the word in the input register
   always_comb begin
      step_in  = step_ff;
      hold_in  = hold_ff;
      armed_in = armed_ff;
      ev_code  = EV_NONE;
      if (!in_word.mode) begin
         if (kill) begin
            if (armed_ff) begin
               ev_code = in_word.link_up ? EV_MANUAL : EV_LINK;
            end
            armed_in = 1'b0;
            step_in  = STEP_WAIT_LOW;
            hold_in  = '0;
         end else begin
            unique case (step_ff)
               STEP_WAIT_LOW: begin
                  if (in_word.throttle < cfg.arm_low_start) begin
                     if (hold_inc >= LOW_HOLD_TICKS) begin
                        hold_in = '0;
                        step_in = STEP_WAIT_HIGH;
                        ev_code = EV_STEP;
                     end else begin
                        hold_in = hold_inc;
                     end
                  end else begin
                     hold_in = '0;
                  end
               end
               STEP_WAIT_HIGH: begin
                  if (in_word.throttle > cfg.arm_high) begin
                     if (hold_inc >= HIGH_HOLD_TICKS) begin
                        hold_in = '0;
                        step_in = STEP_WAIT_LOW_AGAIN;
                        ev_code = EV_STEP;
                     end else begin
                        hold_in = hold_inc;
                     end
                  end else begin
                     hold_in = '0;
                  end
               end
               STEP_WAIT_LOW_AGAIN: begin
                  if (in_word.throttle < cfg.arm_low_done) begin
                     if (hold_inc >= LOW_HOLD_TICKS) begin
                        hold_in  = '0;
                        step_in  = STEP_ARMED;
                        armed_in = 1'b1;
                        ev_code  = EV_STEP;
                     end else begin
                        hold_in = hold_inc;
                     end
                  end else begin
                     hold_in = '0;
                  end
               end
               STEP_ARMED: begin
                  // idle lock: count low throttle, clear on real activity
                  if (in_word.throttle < cfg.arm_low_done) begin
                     if (hold_inc >= IDLE_LOCK_TICKS) begin
                        hold_in  = '0;
                        step_in  = STEP_WAIT_LOW;
                        armed_in = 1'b0;
                        ev_code  = EV_IDLE;
                     end else begin
                        hold_in = hold_inc;
                     end
                  end else if (in_word.throttle > cfg.active_throttle) begin
                     hold_in = '0;
                  end
               end
               default: begin
                  step_in = step_ff;
               end
            endcase
         end
      end
   end

   // commit state only when the word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_WAIT_LOW;
         hold_ff  <= '0;
         armed_ff <= 1'b0;
      end else if (advance) begin
         step_ff  <= step_in;
         hold_ff  <= hold_in;
         armed_ff <= armed_in;
      end
   end

   assign armed_now        = armed_ff;
   assign res_next.armed   = armed_in;
   assign res_next.step    = step_in;
   assign res_next.ev_code = ev_code;

endmodule

@@ rtl/core/mai_pwm_map.sv @@
module mai_pwm_map (
   input  mai_pkg::in_word_type         in_word,
   input  logic                         armed_now,
   input  logic [mai_pkg::PWM_W-1:0]    pwm_max,
   output logic [mai_pkg::PWM_W-1:0]    motor_pwm
);
   import mai_pkg::*;

   localparam int QUOT_FULL_W = PROD_W + RECIP_W;

   logic [QUOT_FULL_W-1:0] quot_full;
   logic [PWM_W-1:0]       quot;

   // divide the scaled product by the 1000-count span via reciprocal
   assign quot_full = QUOT_FULL_W'(in_word.scaled) * QUOT_FULL_W'(RECIP_MULT);
   assign quot      = quot_full[RECIP_SHIFT +: PWM_W];

   // drive zero on arming ticks and while disarmed, saturate at both ends
   always_comb begin
      motor_pwm = '0;
      if (in_word.mode && armed_now) begin
         if (in_word.thr_le_min) begin
            motor_pwm = '0;
         end else if (in_word.thr_ge_max) begin
            motor_pwm = pwm_max;
         end else begin
            motor_pwm = quot;
         end
      end
   end

endmodule

@@ rtl/core/motor_arming_interlock_unit.sv @@
// Motor arming interlock. Each request word is an arming tick (mode 0) that steps the
// low-high-low arm sequence and applies the link-loss, manual-yaw and idle locks, or a
// refresh tick (mode 1) that maps throttle 1000..2000 onto 0..pwm_max while armed. Every
// word yields exactly one response word, in order. A word is accepted every cycle while
// the response side keeps up; its response becomes valid when the word moves from the input
// register into the result register (it enters the input register at the accepting edge).
// The arm state loop closes in the logic between those registers, and the divide by the
// 1000-count span is a reciprocal multiply in that same logic, after the throttle scaling
// multiply ahead of the input register. The user must write registers through the csr
// port only while no word is in flight; the block itself does not enforce this.
module motor_arming_interlock_unit (
   input  logic                            clock,
   input  logic                            reset,
   mai_req_if.sink                         req,
   mai_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [mai_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mai_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mai_pkg::*;

   cfg_type        cfg;
   logic           in_valid;
   in_word_type    in_word;
   logic           advance;
   logic           armed_now;
   arm_result_type res_next;
   logic [PWM_W-1:0] pwm_next;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              armed_ff;
   logic [STEP_W-1:0] step_ff;
   logic [PWM_W-1:0]  pwm_ff;
   logic [EV_W-1:0]   ev_ff;

   // move a word forward when the result register is free or being drained
   assign advance = in_valid && (!rsp_valid_ff || rsp.ready);

   mai_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mai_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .pwm_max  (cfg.pwm_max),
      .advance  (advance),
      .in_valid (in_valid),
      .in_word  (in_word)
   );

   mai_arm_ctrl u_arm_ctrl (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_word   (in_word),
      .cfg       (cfg),
      .armed_now (armed_now),
      .res_next  (res_next)
   );

   mai_pwm_map u_pwm_map (
      .in_word   (in_word),
      .armed_now (armed_now),
      .pwm_max   (cfg.pwm_max),
      .motor_pwm (pwm_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result word; hold it while the sink stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         armed_ff <= res_next.armed;
         step_ff  <= res_next.step;
         pwm_ff   <= pwm_next;
         ev_ff    <= res_next.ev_code;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.armed     = armed_ff;
   assign rsp.arm_step  = step_ff;
   assign rsp.motor_pwm = pwm_ff;
   assign rsp.event_res = ev_ff;

endmodule

@@ rtl/core/mai_checker.sv @@
module mai_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_armed,
   input logic [mai_pkg::STEP_W-1:0]  rsp_arm_step,
   input logic [mai_pkg::PWM_W-1:0]   rsp_motor_pwm,
   input logic [mai_pkg::EV_W-1:0]    rsp_event_res
);
   import mai_pkg::*;

   // armed flag and final sequence step travel together
   a_armed_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_armed == (rsp_arm_step == STEP_ARMED)))
      else $error("armed flag disagrees with sequence step");

   // no motor drive while disarmed
   a_pwm_disarmed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_armed) |-> (rsp_motor_pwm == '0))
      else $error("motor drive while disarmed");

   // a lock event always leaves the sequence at its start
   a_lock_resets: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EV_LINK || rsp_event_res == EV_MANUAL ||
                     rsp_event_res == EV_IDLE))
      |-> (!rsp_armed && rsp_arm_step == STEP_WAIT_LOW))
      else $error("lock event without return to first step");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_armed) &&
         $stable(rsp_arm_step) && $stable(rsp_motor_pwm) && $stable(rsp_event_res)))
      else $error("stalled response word changed");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind motor_arming_interlock_unit mai_checker u_mai_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_armed     (rsp.armed),
   .rsp_arm_step  (rsp.arm_step),
   .rsp_motor_pwm (rsp.motor_pwm),
   .rsp_event_res (rsp.event_res)
);
